/* design/bft_pkg.sv */
`timescale 1ns / 1ps
package bft_pkg;

    // fixed-point format of the frame components
    localparam int FRAME_FRAC_BITS = 30;
    localparam logic [63:0] ONE_Q = 64'd1 << FRAME_FRAC_BITS;
    localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAME_FRAC_BITS - 1);
    localparam logic [63:0] P_LIM = ONE_Q << 1;
    localparam logic signed [31:0] AX_ONE = 32'(ONE_Q);
    localparam logic signed [31:0] AX_MONE = -AX_ONE;

    // node counting
    localparam int MAX_NODES = 65536;
    localparam int NODE_CNT_W = $clog2(MAX_NODES);
    localparam logic [NODE_CNT_W:0] CNT_LIMIT = (NODE_CNT_W + 1)'(MAX_NODES - 1);

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // shared divider
    localparam int DIV_W = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last_node;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        node_index;
        logic signed [31:0] axis1_x;
        logic signed [31:0] axis1_y;
        logic signed [31:0] axis1_z;
        logic signed [31:0] axis2_x;
        logic signed [31:0] axis2_y;
        logic signed [31:0] axis2_z;
        logic signed [31:0] axis3_x;
        logic signed [31:0] axis3_y;
        logic signed [31:0] axis3_z;
        logic               final_frame;
        logic               degenerate;
    } t_out_item;

    // work command from the front to the back
    typedef struct packed {
        logic               single;
        logic               fin;
        logic [15:0]        idx;
        logic signed [32:0] d_x;
        logic signed [32:0] d_y;
        logic signed [32:0] d_z;
    } t_cmd;

endpackage

/* design/beam_frame_transport_unit.sv */
`timescale 1ns / 1ps
// A segment node in the back end takes fifteen divisions on the shared divider,
// three 32-step square roots and the normalize shifts; a single-node beam or a node
// after a zero-length segment skips the divisions and square roots.
// The back end takes one node at a time; the front takes two nodes ahead into the queue.
// Reset (synchronous, active low) clears the queue and sets the frame to identity.
module beam_frame_transport_unit import bft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_cmd f_cmd, q_cmd;
    logic f_push, q_full, q_empty, q_pop;

    bft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_push  (f_push),
        .o_cmd   (f_cmd),
        .i_full  (q_full)
    );

    bft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_cmd),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    bft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data)
    );

endmodule

/* design/bft_front.sv */
`timescale 1ns / 1ps
module bft_front import bft_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    output logic     o_push,
    output t_cmd     o_cmd,
    input  logic     i_full
);

    logic                  r_first_seen, n_first_seen;
    logic [NODE_CNT_W-1:0] r_node_cnt, n_node_cnt;
    logic signed [31:0]    r_prev_x, r_prev_y, r_prev_z;
    logic                  accept;
    logic [NODE_CNT_W:0]   cnt_inc;
    logic                  seg_fin;

    assign o_stall = i_full;
    assign accept  = i_valid & ~i_full;
    assign cnt_inc = {1'b0, r_node_cnt} + (NODE_CNT_W + 1)'(1);
    assign seg_fin = i_data.last_node | (cnt_inc >= CNT_LIMIT);

    // classify the node and build the command
    always_comb begin
        o_push       = 1'b0;
        o_cmd        = '0;
        n_first_seen = r_first_seen;
        n_node_cnt   = r_node_cnt;
        if (accept) begin
            if (!r_first_seen) begin
                if (i_data.last_node) begin
                    o_push       = 1'b1;
                    o_cmd.single = 1'b1;
                    o_cmd.fin    = 1'b1;
                    n_first_seen = 1'b0;
                end else begin
                    n_first_seen = 1'b1;
                end
                n_node_cnt = '0;
            end else begin
                o_push     = 1'b1;
                o_cmd.fin  = seg_fin;
                o_cmd.idx  = 16'(r_node_cnt);
                o_cmd.d_x  = {i_data.pos_x[31], i_data.pos_x} - {r_prev_x[31], r_prev_x};
                o_cmd.d_y  = {i_data.pos_y[31], i_data.pos_y} - {r_prev_y[31], r_prev_y};
                o_cmd.d_z  = {i_data.pos_z[31], i_data.pos_z} - {r_prev_z[31], r_prev_z};
                n_node_cnt = cnt_inc[NODE_CNT_W-1:0];
                if (seg_fin) begin
                    n_first_seen = 1'b0;
                    n_node_cnt   = '0;
                end
            end
        end
    end

    // beam tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_seen <= 1'b0;
            r_node_cnt   <= '0;
        end else begin
            r_first_seen <= n_first_seen;
            r_node_cnt   <= n_node_cnt;
        end
    end

    // previous node position
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_x <= i_data.pos_x;
            r_prev_y <= i_data.pos_y;
            r_prev_z <= i_data.pos_z;
        end
    end

endmodule

/* design/bft_queue.sv */
`timescale 1ns / 1ps
module bft_queue import bft_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty,
    output logic o_full
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

/* design/bft_div.sv */
`timescale 1ns / 1ps
module bft_div import bft_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    logic                 r_busy, r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem, r_quo, r_den;
    logic [DIV_W:0]       trial, diff;
    logic                 ge;

    assign trial  = {r_rem, r_quo[DIV_W-1]};
    assign diff   = trial - {1'b0, r_den};
    assign ge     = (trial >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_quo;

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* design/bft_back.sv */
`timescale 1ns / 1ps
module bft_back import bft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_UV_NORM, S_UV_MUL, S_UV_ACC, S_UV_SQRT, S_UV_DIV, S_UV_DWAIT,
        S_UV_END, S_DOT_MUL, S_DOT_ACC, S_DOT_END, S_DEN_CHK, S_CW_MUL, S_CW_DIV,
        S_CW_DWAIT, S_EMIT, S_EMIT_FIN
    } t_state;

    typedef enum logic [1:0] {UV_SEG, UV_AX2, UV_AX3} t_uv_tgt;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] u;
        u = v;
        mag64 = u[63] ? (~u + 64'd1) : u;
    endfunction

    // round to frame precision and clamp to +-2
    function automatic logic signed [33:0] round_clamp(input logic signed [63:0] v);
        logic [63:0] rs;
        rs = (mag64(v) + ROUND_HALF) >> FRAME_FRAC_BITS;
        if (rs > P_LIM) begin
            rs = P_LIM;
        end
        round_clamp = v[63] ? -$signed(34'(rs)) : $signed(34'(rs));
    endfunction

    t_state             r_state;
    t_uv_tgt            r_uv_tgt;
    logic [1:0]         r_j, r_a;
    logic               r_k, r_qneg, r_degen;
    logic signed [31:0] r_ax1 [3];
    logic signed [31:0] r_ax2 [3];
    logic signed [31:0] r_ax3 [3];
    logic signed [31:0] r_e [3];
    logic signed [31:0] r_n2 [3];
    logic signed [31:0] r_n3 [3];
    logic signed [33:0] r_p [3];
    logic signed [63:0] r_w2 [3];
    logic signed [63:0] r_w3 [3];
    logic [63:0]        r_uv_m [3];
    logic [2:0]         r_uv_neg;
    logic [63:0]        r_acc, r_sx, r_sr, r_sb;
    logic signed [63:0] r_prod;
    t_cmd               r_cmd;
    logic [15:0]        r_fin_idx;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [63:0]        orv, sq_t, acc_sum, den_u;
    logic signed [31:0] ax_sel;
    logic signed [32:0] c_sum;
    logic signed [33:0] mul_a, mul_b, den;
    logic signed [67:0] mul_full;
    logic               can_load, emit_load, div_start, div_done;
    logic [63:0]        div_num, div_den, div_quot, uv_qc;
    logic signed [31:0] uv_q;
    logic signed [63:0] cw_q, d64 [3];
    t_out_item          emit_item;

    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;
    assign can_load  = !r_out_valid || !i_stall;
    assign emit_load = (r_state inside {S_EMIT, S_EMIT_FIN}) && can_load;

    assign orv     = r_uv_m[0] | r_uv_m[1] | r_uv_m[2];
    assign sq_t    = r_sr + r_sb;
    assign acc_sum = r_acc + r_prod;
    assign c_sum   = {r_ax1[r_j][31], r_ax1[r_j]} + {r_e[r_j][31], r_e[r_j]};
    assign den     = $signed(34'(ONE_Q)) + r_p[0];
    assign den_u   = 64'(den);
    assign uv_qc   = (div_quot > ONE_Q) ? ONE_Q : div_quot;
    assign uv_q    = r_uv_neg[r_j] ? -$signed(32'(uv_qc)) : $signed(32'(uv_qc));
    assign cw_q    = r_qneg ? -$signed(div_quot) : $signed(div_quot);

    assign d64[0] = 64'(i_cmd.d_x);
    assign d64[1] = 64'(i_cmd.d_y);
    assign d64[2] = 64'(i_cmd.d_z);

    // axis picked for the dot products
    always_comb begin
        case (r_a)
            2'd0:    ax_sel = r_ax1[r_j];
            2'd1:    ax_sel = r_ax2[r_j];
            default: ax_sel = r_ax3[r_j];
        endcase
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_UV_MUL: begin
                mul_a = $signed({1'b0, r_uv_m[r_j][32:0]});
                mul_b = $signed({1'b0, r_uv_m[r_j][32:0]});
            end
            S_DOT_MUL: begin
                mul_a = {{2{r_e[r_j][31]}}, r_e[r_j]};
                mul_b = {{2{ax_sel[31]}}, ax_sel};
            end
            S_CW_MUL: begin
                mul_a = {c_sum[32], c_sum};
                mul_b = r_k ? r_p[2] : r_p[1];
            end
            default: begin
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[63:0];
    end

    // divider requests
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_UV_DIV: begin
                div_start = 1'b1;
                div_num   = (r_uv_m[r_j] << FRAME_FRAC_BITS) + (r_sr >> 1);
                div_den   = r_sr;
            end
            S_CW_DIV: begin
                div_start = 1'b1;
                div_num   = mag64(r_prod) + (den_u >> 1);
                div_den   = den_u;
            end
            default: begin
            end
        endcase
    end

    bft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // result transaction built from the current frame
    always_comb begin
        emit_item.axis1_x = r_ax1[0];
        emit_item.axis1_y = r_ax1[1];
        emit_item.axis1_z = r_ax1[2];
        emit_item.axis2_x = r_ax2[0];
        emit_item.axis2_y = r_ax2[1];
        emit_item.axis2_z = r_ax2[2];
        emit_item.axis3_x = r_ax3[0];
        emit_item.axis3_y = r_ax3[1];
        emit_item.axis3_z = r_ax3[2];
        if (r_state == S_EMIT) begin
            emit_item.node_index  = r_cmd.idx;
            emit_item.final_frame = 1'b0;
            emit_item.degenerate  = r_degen;
        end else begin
            emit_item.node_index  = r_fin_idx;
            emit_item.final_frame = 1'b1;
            emit_item.degenerate  = 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ax1[0] <= AX_ONE; r_ax1[1] <= '0;     r_ax1[2] <= '0;
            r_ax2[0] <= '0;     r_ax2[1] <= AX_ONE; r_ax2[2] <= '0;
            r_ax3[0] <= '0;     r_ax3[1] <= '0;     r_ax3[2] <= AX_ONE;
        end else begin
            // output register drains unless a new transaction loads it
            if (r_out_valid && !i_stall && !emit_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.single) begin
                            r_fin_idx <= '0;
                            r_state   <= S_EMIT_FIN;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_uv_m[i]   <= mag64(d64[i]);
                                r_uv_neg[i] <= d64[i][63];
                            end
                            r_uv_tgt <= UV_SEG;
                            r_degen  <= 1'b0;
                            r_state  <= S_UV_NORM;
                        end
                    end
                end
                // bring the largest magnitude into [2^30, 2^31)
                S_UV_NORM: begin
                    if (orv == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_EMIT;
                    end else if (|orv[63:31]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_uv_m[i] <= r_uv_m[i] >> 1;
                        end
                    end else if (!orv[30]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_uv_m[i] <= r_uv_m[i] << 1;
                        end
                    end else begin
                        r_acc   <= '0;
                        r_j     <= '0;
                        r_state <= S_UV_MUL;
                    end
                end
                S_UV_MUL: begin
                    r_state <= S_UV_ACC;
                end
                S_UV_ACC: begin
                    r_acc <= acc_sum;
                    if (r_j == 2'd2) begin
                        r_sx    <= acc_sum;
                        r_sr    <= '0;
                        r_sb    <= 64'd1 << 62;
                        r_j     <= '0;
                        r_state <= S_UV_SQRT;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_UV_MUL;
                    end
                end
                // integer square root, one bit pair per cycle
                S_UV_SQRT: begin
                    if (r_sb == '0) begin
                        r_state <= S_UV_DIV;
                    end else begin
                        if (r_sx >= sq_t) begin
                            r_sx <= r_sx - sq_t;
                            r_sr <= (r_sr >> 1) + r_sb;
                        end else begin
                            r_sr <= r_sr >> 1;
                        end
                        r_sb <= r_sb >> 2;
                    end
                end
                S_UV_DIV: begin
                    r_state <= S_UV_DWAIT;
                end
                S_UV_DWAIT: begin
                    if (div_done) begin
                        case (r_uv_tgt)
                            UV_SEG:  r_e[r_j]  <= uv_q;
                            UV_AX2:  r_n2[r_j] <= uv_q;
                            default: r_n3[r_j] <= uv_q;
                        endcase
                        if (r_j == 2'd2) begin
                            r_state <= S_UV_END;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_UV_DIV;
                        end
                    end
                end
                S_UV_END: begin
                    case (r_uv_tgt)
                        UV_SEG: begin
                            // first segment pointing back along x flips the start frame
                            if (r_cmd.idx == '0 && r_e[0] == AX_MONE) begin
                                r_ax1[0] <= AX_MONE; r_ax1[1] <= '0;      r_ax1[2] <= '0;
                                r_ax2[0] <= '0;      r_ax2[1] <= AX_MONE; r_ax2[2] <= '0;
                                r_ax3[0] <= '0;      r_ax3[1] <= '0;      r_ax3[2] <= AX_ONE;
                            end
                            r_a     <= '0;
                            r_j     <= '0;
                            r_acc   <= '0;
                            r_state <= S_DOT_MUL;
                        end
                        UV_AX2: begin
                            for (int i = 0; i < 3; i++) begin
                                r_uv_m[i]   <= mag64(r_w3[i]);
                                r_uv_neg[i] <= r_w3[i][63];
                            end
                            r_uv_tgt <= UV_AX3;
                            r_state  <= S_UV_NORM;
                        end
                        default: begin
                            for (int i = 0; i < 3; i++) begin
                                r_ax1[i] <= r_e[i];
                                r_ax2[i] <= r_n2[i];
                                r_ax3[i] <= r_n3[i];
                            end
                            r_degen <= 1'b0;
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                // projections of the direction onto the three axes
                S_DOT_MUL: begin
                    r_state <= S_DOT_ACC;
                end
                S_DOT_ACC: begin
                    r_acc <= acc_sum;
                    if (r_j == 2'd2) begin
                        r_state <= S_DOT_END;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_DOT_MUL;
                    end
                end
                S_DOT_END: begin
                    r_p[r_a] <= round_clamp($signed(r_acc));
                    r_acc    <= '0;
                    r_j      <= '0;
                    if (r_a == 2'd2) begin
                        r_state <= S_DEN_CHK;
                    end else begin
                        r_a     <= r_a + 2'd1;
                        r_state <= S_DOT_MUL;
                    end
                end
                S_DEN_CHK: begin
                    if (den[33] || den == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_j     <= '0;
                        r_k     <= 1'b0;
                        r_state <= S_CW_MUL;
                    end
                end
                // rotate axes 2 and 3, one component per pass
                S_CW_MUL: begin
                    r_state <= S_CW_DIV;
                end
                S_CW_DIV: begin
                    r_qneg  <= r_prod[63];
                    r_state <= S_CW_DWAIT;
                end
                S_CW_DWAIT: begin
                    if (div_done) begin
                        if (!r_k) begin
                            r_w2[r_j] <= 64'(r_ax2[r_j]) - cw_q;
                            r_k       <= 1'b1;
                            r_state   <= S_CW_MUL;
                        end else begin
                            r_w3[r_j] <= 64'(r_ax3[r_j]) - cw_q;
                            r_k       <= 1'b0;
                            if (r_j == 2'd2) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_uv_m[i]   <= mag64(r_w2[i]);
                                    r_uv_neg[i] <= r_w2[i][63];
                                end
                                r_uv_tgt <= UV_AX2;
                                r_state  <= S_UV_NORM;
                            end else begin
                                r_j     <= r_j + 2'd1;
                                r_state <= S_CW_MUL;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (can_load) begin
                        r_out       <= emit_item;
                        r_out_valid <= 1'b1;
                        if (r_cmd.fin) begin
                            r_fin_idx <= r_cmd.idx + 16'd1;
                            r_state   <= S_EMIT_FIN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                // closing transaction, then back to the identity frame
                S_EMIT_FIN: begin
                    if (can_load) begin
                        r_out       <= emit_item;
                        r_out_valid <= 1'b1;
                        r_ax1[0] <= AX_ONE; r_ax1[1] <= '0;     r_ax1[2] <= '0;
                        r_ax2[0] <= '0;     r_ax2[1] <= AX_ONE; r_ax2[2] <= '0;
                        r_ax3[0] <= '0;     r_ax3[1] <= '0;     r_ax3[2] <= AX_ONE;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/bft_checker.sv */
`timescale 1ns / 1ps
module bft_checker import bft_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a stalled result transaction stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // the closing result of a beam is never degenerate
    a_final_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.final_frame && o_out_data.degenerate))
        else $error("final result flagged degenerate");

    // diagonal frame components are unit bounded
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.axis1_x <= AX_ONE && o_out_data.axis1_x >= AX_MONE
            && o_out_data.axis2_y <= AX_ONE && o_out_data.axis2_y >= AX_MONE
            && o_out_data.axis3_z <= AX_ONE && o_out_data.axis3_z >= AX_MONE)
        else $error("frame component out of range");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind beam_frame_transport_unit bft_checker u_bft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
